FILE: src/shape_table_pixel_coverage_macros.svh
// assertion helpers for the shape table rtl
`ifndef SHAPE_TABLE_PIXEL_COVERAGE_MACROS_SVH
`define SHAPE_TABLE_PIXEL_COVERAGE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define STPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define STPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stpc_pkg.sv
package stpc_pkg;

  localparam int unsigned MAX_SHAPES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 4;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned RADIUS_W   = 15;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned HIT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_RECT    = 2'd2,
    KIND_CIRCLE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_GEOM = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAW_DEPTH   = 1'b0,
    CFG_DEPTH_FILTER = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_RESULT
  } back_state_e;

  // decoded item as it waits in the queue; bx carries the radius for circles
  typedef struct packed {
    op_e                       op;
    kind_e                     kind;
    logic                      bad;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [DEPTH_W-1:0]        depth;
    logic [PIX_W-1:0]          qx;
    logic [PIX_W-1:0]          qy;
  } item_t;

  // one table entry
  typedef struct packed {
    kind_e                     kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [DEPTH_W-1:0]        layer;
  } shape_t;

endpackage

FILE: src/shape_table_pixel_coverage.sv
// channel   direction  handshake                  payload
// in        to block   in_valid_i / in_ready_o    op, kind, ax, ay, bx, by, radius, depth,
//                                                 query_x, query_y
// out       from block out_valid_o / out_ready_i  filled, hit_index, status
// cfg       to block   cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// an add item is taken by the executor once the output register is free
// a query item holds the executor for the table scan, skipped on an empty table, which
// takes one stored shape per cycle through the registered table read and the multiply
// stage, then drains the pipeline and loads the result once the output register is free
// reset is asynchronous and clears control state and the shape count; the table
// contents are left as they are, there is no clearing pass
// a two-entry queue sits between decode and the executor, so up to two items keep coming in
// while a query scans or a result waits in the output register
module shape_table_pixel_coverage #(
  parameter int unsigned MAX_SHAPES = stpc_pkg::MAX_SHAPES_DEF,
  parameter int unsigned FRAC_BITS  = stpc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [1:0]                          kind_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] ax_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] ay_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] bx_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] by_i,
  input  logic [stpc_pkg::RADIUS_W-1:0]       radius_i,
  input  logic [stpc_pkg::DEPTH_W-1:0]        depth_i,
  input  logic [stpc_pkg::PIX_W-1:0]          query_x_i,
  input  logic [stpc_pkg::PIX_W-1:0]          query_y_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                filled_o,
  output logic [stpc_pkg::HIT_W-1:0]          hit_index_o,
  output logic [1:0]                          status_o,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [stpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [stpc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // decoded item from the front end into the queue
  logic            push_valid;
  logic            push_ready;
  stpc_pkg::item_t push_item;

  // queue head into the executor
  logic            pop_valid;
  logic            pop_ready;
  stpc_pkg::item_t pop_item;

  // front end: geometry check, circle radius folded into bx
  stpc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .kind_i       (kind_i),
    .ax_i         (ax_i),
    .ay_i         (ay_i),
    .bx_i         (bx_i),
    .by_i         (by_i),
    .radius_i     (radius_i),
    .depth_i      (depth_i),
    .query_x_i    (query_x_i),
    .query_y_i    (query_y_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decouples intake from the scanning executor
  stpc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // executor: shape table, in-order coverage scan, result register
  stpc_back #(
    .MAX_SHAPES (MAX_SHAPES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_item_i    (pop_item),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .filled_o    (filled_o),
    .hit_index_o (hit_index_o),
    .status_o    (status_o)
  );

endmodule

FILE: src/stpc_front.sv
module stpc_front (
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [1:0]                         kind_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] ax_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] ay_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] bx_i,
  input  logic signed [stpc_pkg::COORD_W-1:0] by_i,
  input  logic [stpc_pkg::RADIUS_W-1:0]      radius_i,
  input  logic [stpc_pkg::DEPTH_W-1:0]       depth_i,
  input  logic [stpc_pkg::PIX_W-1:0]         query_x_i,
  input  logic [stpc_pkg::PIX_W-1:0]         query_y_i,
  output logic                               push_valid_o,
  input  logic                               push_ready_i,
  output stpc_pkg::item_t                    push_item_o
);

  stpc_pkg::kind_e kind;
  logic            bad;
  logic            same_x;
  logic            same_y;

  assign kind   = stpc_pkg::kind_e'(kind_i);
  assign same_x = (ax_i == bx_i);
  assign same_y = (ay_i == by_i);

  // geometry rejection rules
  always_comb begin
    case (kind)
      stpc_pkg::KIND_SEGMENT: bad = (!same_x && !same_y) || (same_x && same_y);
      stpc_pkg::KIND_RECT:    bad = same_x || same_y;
      stpc_pkg::KIND_CIRCLE:  bad = (radius_i == '0);
      default:                bad = 1'b0;
    endcase
  end

  always_comb begin
    push_item_o.op    = stpc_pkg::op_e'(op_i);
    push_item_o.kind  = kind;
    push_item_o.bad   = bad;
    push_item_o.ax    = ax_i;
    push_item_o.ay    = ay_i;
    push_item_o.bx    = (kind == stpc_pkg::KIND_CIRCLE) ? signed'({1'b0, radius_i}) : bx_i;
    push_item_o.by    = by_i;
    push_item_o.depth = depth_i;
    push_item_o.qx    = query_x_i;
    push_item_o.qy    = query_y_i;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

FILE: src/stpc_queue.sv
module stpc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  stpc_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output stpc_pkg::item_t pop_item_o
);

  // two-entry fifo
  stpc_pkg::item_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: src/stpc_back.sv
`include "shape_table_pixel_coverage_macros.svh"

module stpc_back #(
  parameter int unsigned MAX_SHAPES = stpc_pkg::MAX_SHAPES_DEF,
  parameter int unsigned FRAC_BITS  = stpc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  stpc_pkg::item_t                   q_item_i,
  input  logic                              cfg_we_i,
  input  logic [stpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [stpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              filled_o,
  output logic [stpc_pkg::HIT_W-1:0]        hit_index_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SHAPES + 1);
  localparam int unsigned QW    = stpc_pkg::PIX_W + FRAC_BITS;
  localparam int unsigned DW    = ((QW + 1 > stpc_pkg::COORD_W) ? QW + 1 : stpc_pkg::COORD_W) + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned RW    = 2 * stpc_pkg::RADIUS_W;
  localparam int unsigned CW    = stpc_pkg::COORD_W;

  // configuration registers
  logic [stpc_pkg::DEPTH_W-1:0] draw_depth_q;
  logic                         filter_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_depth_q <= '0;
      filter_on_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (stpc_pkg::cfg_reg_e'(cfg_idx_i))
        stpc_pkg::CFG_DRAW_DEPTH:   draw_depth_q <= cfg_wdata_i;
        stpc_pkg::CFG_DEPTH_FILTER: filter_on_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // shape table
  stpc_pkg::shape_t mem_q [MAX_SHAPES];
  stpc_pkg::shape_t rd_data_q;
  stpc_pkg::shape_t wr_data;

  stpc_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]      next_idx_ext;
  logic                  last;
  logic                  full;
  logic                  slot_free;
  logic                  pop;
  logic                  issue;
  logic                  mem_we;
  logic                  qlatch;
  logic                  ld;
  logic                  ld_filled;
  logic [IDX_W+stpc_pkg::HIT_W-1:0] ld_hit;
  stpc_pkg::status_e     ld_status;

  logic [QW-1:0]         px_q, py_q;

  // pipeline: s1 holds the read entry, s2 the products
  logic                  s1_vld_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  s2_vld_q;
  logic [IDX_W-1:0]      s2_idx_q;
  logic                  s2_elig_q;
  logic                  s2_circ_q;
  logic                  s2_box_hit_q;
  logic [PW-1:0]         dx2_q, dy2_q;
  logic [RW-1:0]         rr_q;

  logic                  found_q;
  logic [IDX_W-1:0]      hit_idx_q;

  logic                  out_vld_q;
  logic                  filled_q;
  logic [stpc_pkg::HIT_W-1:0] hit_q;
  logic [1:0]            status_q;

  assign full         = (cnt_q == CNT_W'(MAX_SHAPES));
  assign slot_free    = !out_vld_q || out_ready_i;
  assign next_idx_ext = CNT_W'(rd_idx_q) + CNT_W'(1);
  assign last         = (next_idx_ext == cnt_q);
  assign q_ready_o    = pop;

  always_comb begin
    wr_data.kind  = q_item_i.kind;
    wr_data.ax    = q_item_i.ax;
    wr_data.ay    = q_item_i.ay;
    wr_data.bx    = q_item_i.bx;
    wr_data.by    = q_item_i.by;
    wr_data.layer = q_item_i.depth;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    pop       = 1'b0;
    issue     = 1'b0;
    mem_we    = 1'b0;
    qlatch    = 1'b0;
    ld        = 1'b0;
    ld_filled = 1'b0;
    ld_hit    = '0;
    ld_status = stpc_pkg::ST_OK;
    case (state_q)
      stpc_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == stpc_pkg::OP_ADD) begin
            if (slot_free) begin
              pop = 1'b1;
              ld  = 1'b1;
              if (q_item_i.bad) begin
                ld_status = stpc_pkg::ST_BAD_GEOM;
              end else if (full) begin
                ld_status = stpc_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
          end else begin
            pop      = 1'b1;
            qlatch   = 1'b1;
            rd_idx_d = '0;
            state_d  = (cnt_q == '0) ? stpc_pkg::BK_RESULT : stpc_pkg::BK_SCAN;
          end
        end
      end
      stpc_pkg::BK_SCAN: begin
        issue = 1'b1;
        if (last) begin
          state_d = stpc_pkg::BK_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
      end
      stpc_pkg::BK_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = stpc_pkg::BK_RESULT;
        end
      end
      stpc_pkg::BK_RESULT: begin
        if (slot_free) begin
          ld        = 1'b1;
          ld_filled = found_q;
          ld_hit    = found_q ? (IDX_W + stpc_pkg::HIT_W)'(hit_idx_q) : '0;
          state_d   = stpc_pkg::BK_IDLE;
        end
      end
      default: state_d = stpc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stpc_pkg::BK_IDLE;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[IDX_W-1:0]] <= wr_data;
    end
    rd_data_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (qlatch) begin
      px_q <= QW'(q_item_i.qx) << FRAC_BITS;
      py_q <= QW'(q_item_i.qy) << FRAC_BITS;
    end
  end

  // s1: differences, box and point tests, products
  logic signed [DW-1:0] pxs, pys, axs, ays, los_x, his_x, los_y, his_y;
  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] dx2, dy2;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                 elig;
  logic                 box_hit;

  assign pxs   = signed'({{(DW-QW){1'b0}}, px_q});
  assign pys   = signed'({{(DW-QW){1'b0}}, py_q});
  assign axs   = signed'({{(DW-CW){rd_data_q.ax[CW-1]}}, rd_data_q.ax});
  assign ays   = signed'({{(DW-CW){rd_data_q.ay[CW-1]}}, rd_data_q.ay});
  assign lo_x  = (rd_data_q.ax < rd_data_q.bx) ? rd_data_q.ax : rd_data_q.bx;
  assign hi_x  = (rd_data_q.ax < rd_data_q.bx) ? rd_data_q.bx : rd_data_q.ax;
  assign lo_y  = (rd_data_q.ay < rd_data_q.by) ? rd_data_q.ay : rd_data_q.by;
  assign hi_y  = (rd_data_q.ay < rd_data_q.by) ? rd_data_q.by : rd_data_q.ay;
  assign los_x = signed'({{(DW-CW){lo_x[CW-1]}}, lo_x});
  assign his_x = signed'({{(DW-CW){hi_x[CW-1]}}, hi_x});
  assign los_y = signed'({{(DW-CW){lo_y[CW-1]}}, lo_y});
  assign his_y = signed'({{(DW-CW){hi_y[CW-1]}}, hi_y});
  assign dx    = pxs - axs;
  assign dy    = pys - ays;
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign elig  = !filter_on_q || (rd_data_q.layer <= draw_depth_q);

  always_comb begin
    case (rd_data_q.kind)
      stpc_pkg::KIND_POINT: box_hit = (pxs == axs) && (pys == ays);
      stpc_pkg::KIND_SEGMENT,
      stpc_pkg::KIND_RECT:  box_hit = (pxs >= los_x) && (pxs <= his_x) &&
                                      (pys >= los_y) && (pys <= his_y);
      default:              box_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q     <= rd_idx_q;
    s2_idx_q     <= s1_idx_q;
    s2_elig_q    <= elig;
    s2_circ_q    <= (rd_data_q.kind == stpc_pkg::KIND_CIRCLE);
    s2_box_hit_q <= box_hit;
    dx2_q        <= dx2;
    dy2_q        <= dy2;
    rr_q         <= rd_data_q.bx[stpc_pkg::RADIUS_W-1:0] * rd_data_q.bx[stpc_pkg::RADIUS_W-1:0];
  end

  // s2: squared distance against squared radius
  logic [PW:0] d2;
  logic        s2_hit;

  assign d2     = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign s2_hit = s2_elig_q && (s2_circ_q ? (d2 <= (PW + 1)'(rr_q)) : s2_box_hit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (qlatch) begin
        found_q <= 1'b0;
      end else if (s2_vld_q && s2_hit && !found_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_hit && !found_q) begin
      hit_idx_q <= s2_idx_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      filled_q <= ld_filled;
      hit_q    <= ld_hit[stpc_pkg::HIT_W-1:0];
      status_q <= ld_status;
    end
  end

  assign out_valid_o = out_vld_q;
  assign filled_o    = filled_q;
  assign hit_index_o = hit_q;
  assign status_o    = status_q;

  `STPC_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(MAX_SHAPES), "shape count past table size")
  `STPC_ASSERT_NXT(a_full_keeps_cnt, clk_i, rst_ni, pop && (q_item_i.op == stpc_pkg::OP_ADD) && full, $stable(cnt_q), "add into full table changed count")
  `STPC_ASSERT_IMP(a_idle_drained, clk_i, rst_ni, state_q == stpc_pkg::BK_IDLE, !s1_vld_q && !s2_vld_q, "scan pipeline busy while idle")
  `STPC_ASSERT_IMP(a_hit_in_table, clk_i, rst_ni, found_q, CNT_W'(hit_idx_q) < cnt_q, "hit index beyond stored shapes")

endmodule

FILE: tb/stpc_coverage_checker.sv
`timescale 1ns / 1ps

module stpc_coverage_checker
  import stpc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       op_i,
  input  logic [1:0]                 kind_i,
  input  logic signed [COORD_W-1:0]  ax_i,
  input  logic signed [COORD_W-1:0]  ay_i,
  input  logic signed [COORD_W-1:0]  bx_i,
  input  logic signed [COORD_W-1:0]  by_i,
  input  logic [RADIUS_W-1:0]        radius_i,
  input  logic [DEPTH_W-1:0]         depth_i,
  input  logic [PIX_W-1:0]           query_x_i,
  input  logic [PIX_W-1:0]           query_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       filled_i,
  input  logic [HIT_W-1:0]           hit_index_i,
  input  logic [1:0]                 status_i,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  output int                         fail_count_o,
  output int                         owed_o,
  output int                         adds_stored_o,
  output int                         adds_bad_o,
  output int                         adds_full_o,
  output int                         queries_hit_o,
  output int                         queries_miss_o
);

  typedef struct packed {
    logic             filled;
    logic [HIT_W-1:0] hit;
    status_e          status;
  } coverage_t;

  shape_t             shapes [MAX_SHAPES_DEF];
  int unsigned        shape_total;
  logic [DEPTH_W-1:0] depth_limit;
  logic               filter_on;
  coverage_t          owed_results [$];

  function automatic bit covers_pixel(shape_t s, longint px, longint py);
    longint ax, ay, bx, by, dx, dy;
    ax = $signed(s.ax);
    ay = $signed(s.ay);
    bx = $signed(s.bx);
    by = $signed(s.by);
    case (s.kind)
      KIND_POINT: return (px == ax) && (py == ay);
      KIND_CIRCLE: begin
        // bx holds the radius
        dx = px - ax;
        dy = py - ay;
        return (dx * dx + dy * dy) <= (bx * bx);
      end
      default: begin
        return (px >= (ax < bx ? ax : bx)) && (px <= (ax > bx ? ax : bx)) &&
               (py >= (ay < by ? ay : by)) && (py <= (ay > by ? ay : by));
      end
    endcase
  endfunction

  // applies one item to the shadow table and returns its result
  function automatic coverage_t table_outcome(
    op_e op, kind_e kind,
    logic signed [COORD_W-1:0] ax, ay, bx, by,
    logic [RADIUS_W-1:0] radius, logic [DEPTH_W-1:0] depth,
    logic [PIX_W-1:0] qx, qy
  );
    coverage_t   res;
    shape_t      entry;
    logic        bad;
    longint      px, py;
    bit          found;
    int unsigned idx;
    res.filled = 1'b0;
    res.hit    = '0;
    res.status = ST_OK;
    if (op == OP_ADD) begin
      case (kind)
        KIND_SEGMENT: bad = (ax != bx && ay != by) || (ax == bx && ay == by);
        KIND_RECT:    bad = (ax == bx) || (ay == by);
        KIND_CIRCLE:  bad = (radius == '0);
        default:      bad = 1'b0;
      endcase
      // geometry wins over a full table
      if (bad) begin
        res.status = ST_BAD_GEOM;
      end else if (shape_total >= MAX_SHAPES_DEF) begin
        res.status = ST_FULL;
      end else begin
        entry.kind  = kind;
        entry.ax    = ax;
        entry.ay    = ay;
        entry.bx    = (kind == KIND_CIRCLE) ? {1'b0, radius} : bx;
        entry.by    = by;
        entry.layer = depth;
        shapes[shape_total] = entry;
        shape_total++;
      end
    end else begin
      px = longint'(qx) << FRAC_BITS_DEF;
      py = longint'(qy) << FRAC_BITS_DEF;
      found = 1'b0;
      for (idx = 0; idx < shape_total; idx++) begin
        if (!found && !(filter_on && shapes[idx].layer > depth_limit) &&
            covers_pixel(shapes[idx], px, py)) begin
          found      = 1'b1;
          res.filled = 1'b1;
          res.hit    = idx[HIT_W-1:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coverage_t want;
    coverage_t got_pred;
    if (!rst_ni) begin
      shape_total    = 0;
      depth_limit    = '0;
      filter_on      = 1'b0;
      owed_results.delete();
      fail_count_o   = 0;
      owed_o         = 0;
      adds_stored_o  = 0;
      adds_bad_o     = 0;
      adds_full_o    = 0;
      queries_hit_o  = 0;
      queries_miss_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_DRAW_DEPTH:   depth_limit = cfg_wdata_i;
          CFG_DEPTH_FILTER: filter_on   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // results leave before this edge's item is counted
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result: filled %0d hit_index %0d status %0d",
                 filled_i, hit_index_i, status_i);
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          if (filled_i !== want.filled) begin
            $error("filled: expected %0d, actual %0d", want.filled, filled_i);
            fail_count_o++;
          end
          if (hit_index_i !== want.hit) begin
            $error("hit_index: expected %0d, actual %0d", want.hit, hit_index_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        got_pred = table_outcome(op_e'(op_i), kind_e'(kind_i), ax_i, ay_i, bx_i, by_i,
                                 radius_i, depth_i, query_x_i, query_y_i);
        owed_results = {owed_results, got_pred};
        if (op_e'(op_i) == OP_QUERY) begin
          if (got_pred.filled) queries_hit_o++;
          else queries_miss_o++;
        end else begin
          case (got_pred.status)
            ST_OK:       adds_stored_o++;
            ST_BAD_GEOM: adds_bad_o++;
            default:     adds_full_o++;
          endcase
        end
      end
      owed_o = owed_results.size();
    end
  end

endmodule

FILE: tb/tb_shape_table_pixel_coverage.sv
`timescale 1ns / 1ps

module tb_shape_table_pixel_coverage;
  import stpc_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT     = 5000;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 6;
  // a query scans the whole table; leave room for it after the last result
  localparam int SETTLE_CYCLES   = 24;

  logic                      clk;
  logic                      rst_n;

  // item channel
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_op;
  logic [1:0]                in_kind;
  logic signed [COORD_W-1:0] in_ax;
  logic signed [COORD_W-1:0] in_ay;
  logic signed [COORD_W-1:0] in_bx;
  logic signed [COORD_W-1:0] in_by;
  logic [RADIUS_W-1:0]       in_radius;
  logic [DEPTH_W-1:0]        in_depth;
  logic [PIX_W-1:0]          in_qx;
  logic [PIX_W-1:0]          in_qy;

  // result channel
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_filled;
  logic [HIT_W-1:0]          out_hit;
  logic [1:0]                out_status;

  // register writes
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_idx;
  logic [CFG_DATA_W-1:0]     cfg_wdata;

  // handshake seen at the last rising edge, read by the driver at the falling edge
  logic                      in_fire;
  int                        send_idle_pct;
  int                        recv_idle_pct;
  int                        quiet_cycles;

  int fail_count, owed, adds_stored, adds_bad, adds_full, queries_hit, queries_miss;

  shape_table_pixel_coverage dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (in_op),
    .kind_i      (in_kind),
    .ax_i        (in_ax),
    .ay_i        (in_ay),
    .bx_i        (in_bx),
    .by_i        (in_by),
    .radius_i    (in_radius),
    .depth_i     (in_depth),
    .query_x_i   (in_qx),
    .query_y_i   (in_qy),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .filled_o    (out_filled),
    .hit_index_o (out_hit),
    .status_o    (out_status),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  stpc_coverage_checker coverage_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .op_i           (in_op),
    .kind_i         (in_kind),
    .ax_i           (in_ax),
    .ay_i           (in_ay),
    .bx_i           (in_bx),
    .by_i           (in_by),
    .radius_i       (in_radius),
    .depth_i        (in_depth),
    .query_x_i      (in_qx),
    .query_y_i      (in_qy),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .filled_i       (out_filled),
    .hit_index_i    (out_hit),
    .status_i       (out_status),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .owed_o         (owed),
    .adds_stored_o  (adds_stored),
    .adds_bad_o     (adds_bad),
    .adds_full_o    (adds_full),
    .queries_hit_o  (queries_hit),
    .queries_miss_o (queries_miss)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sampled in the active region, so it sees the values from before the edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // hang detector: any handshake on either channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[shape_table_pixel_coverage] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drives one item at a falling edge and holds it until accepted; the sender
  // may first drop valid for a random gap
  task automatic send_item(
    op_e op, kind_e kind,
    logic signed [COORD_W-1:0] ax, ay, bx, by,
    logic [RADIUS_W-1:0] radius, logic [DEPTH_W-1:0] depth,
    logic [PIX_W-1:0] qx, qy
  );
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_op     <= op;
    in_kind   <= kind;
    in_ax     <= ax;
    in_ay     <= ay;
    in_bx     <= bx;
    in_by     <= by;
    in_radius <= radius;
    in_depth  <= depth;
    in_qx     <= qx;
    in_qy     <= qy;
    in_valid  <= 1'b1;
    do @(negedge clk); while (!in_fire);
  endtask

  // the query pixel is don't-care on an add, so it gets random bits
  task automatic send_add(
    kind_e kind, logic signed [COORD_W-1:0] ax, ay, bx, by,
    logic [RADIUS_W-1:0] radius, logic [DEPTH_W-1:0] depth
  );
    send_item(OP_ADD, kind, ax, ay, bx, by, radius, depth, 11'($urandom), 11'($urandom));
  endtask

  // and the shape fields are don't-care on a query
  task automatic send_query(logic [PIX_W-1:0] qx, logic [PIX_W-1:0] qy);
    send_item(OP_QUERY, kind_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 15'($urandom), 8'($urandom), qx, qy);
  endtask

  // sender holds off until the block has handed back every result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
  endtask

  // coordinate on the first 128 pixels, on the integer grid at least half the time
  function automatic logic signed [COORD_W-1:0] window_coord();
    return 16'($urandom_range(0, 127) * 16 + ($urandom_range(0, 1) ? $urandom_range(0, 15) : 0));
  endfunction

  initial begin
    kind_e                     kind;
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic [RADIUS_W-1:0]       radius;
    logic [DEPTH_W-1:0]        depth_setting;
    logic                      filter_setting;

    // everything known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_ADD;
    in_kind       = KIND_POINT;
    in_ax         = '0;
    in_ay         = '0;
    in_bx         = '0;
    in_by         = '0;
    in_radius     = '0;
    in_depth      = '0;
    in_qx         = '0;
    in_qy         = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_DRAW_DEPTH;
    cfg_wdata     = '0;
    send_idle_pct = 11;
    recv_idle_pct = 61;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, registers at reset values: no filtering
    send_query(11'd0, 11'd0);                                                  // empty table
    send_add(KIND_POINT, 16'sd80, 16'sd80, 16'sd0, 16'sd0, 15'd0, 8'd0);      // slot 0
    send_add(KIND_SEGMENT, 16'sd160, 16'sd160, 16'sd160, 16'sd160, 15'd0, 8'd1); // zero length
    send_add(KIND_SEGMENT, 16'sd160, 16'sd32, 16'sd480, 16'sd96, 15'd0, 8'd1);   // diagonal
    send_add(KIND_SEGMENT, 16'sd160, 16'sd32, 16'sd480, 16'sd32, 15'd0, 8'd10);  // slot 1
    send_add(KIND_SEGMENT, 16'sd640, 16'sd320, 16'sd640, 16'sd0, 15'd0, 8'd20);  // slot 2
    send_add(KIND_RECT, 16'sd320, 16'sd320, 16'sd320, 16'sd800, 15'd0, 8'd5);    // flat in x
    send_add(KIND_RECT, 16'sd320, 16'sd320, 16'sd800, 16'sd320, 15'd0, 8'd5);    // flat in y
    send_add(KIND_RECT, 16'sd800, 16'sd800, 16'sd320, 16'sd320, 15'd0, 8'd100);  // slot 3
    send_add(KIND_CIRCLE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0, 8'd7);          // no radius
    send_add(KIND_CIRCLE, 16'sd320, 16'sd1280, 16'sd0, 16'sd0, 15'd64, 8'd50);   // slot 4
    send_add(KIND_POINT, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 15'd0, 8'd255); // slot 5
    send_add(KIND_CIRCLE, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 15'd32767, 8'd200);
    // slot 7 covers every pixel, so later queries always find something when it counts
    send_add(KIND_RECT, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 15'd0, 8'd255);
    send_query(11'd5, 11'd5);       // point
    send_query(11'd10, 11'd2);      // segment start
    send_query(11'd30, 11'd2);      // segment end
    send_query(11'd40, 11'd20);     // vertical segment end
    send_query(11'd50, 11'd50);     // far rectangle corner
    send_query(11'd24, 11'd80);     // exactly on the circle edge
    send_query(11'd25, 11'd80);     // just outside, falls to the catch-all
    send_query(11'd2047, 11'd2047); // largest pixel
    send_query(11'd0, 11'd0);

    // random part: each phase runs under its own depth filter setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_results_drained();
      case (phase)
        0:       begin depth_setting = 8'd0;   filter_setting = 1'b1; end
        1:       begin depth_setting = 8'd255; filter_setting = 1'b1; end
        2:       begin depth_setting = 8'($urandom_range(1, 254)); filter_setting = 1'b1; end
        3:       begin depth_setting = 8'($urandom); filter_setting = 1'b0; end
        4:       begin depth_setting = 8'd128; filter_setting = 1'b1; end
        default: begin depth_setting = 8'($urandom); filter_setting = 1'b1; end
      endcase
      // idling: sender light / receiver heavy, then swapped, then none
      send_idle_pct = (phase < 2) ? 11 : (phase < 4) ? 61 : 0;
      recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 11 : 0;

      // two back-to-back writes; only bit 0 of the filter write matters
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_DRAW_DEPTH;
      cfg_wdata <= depth_setting;
      @(negedge clk);
      cfg_idx   <= CFG_DEPTH_FILTER;
      cfg_wdata <= {7'($urandom), filter_setting};
      @(negedge clk);
      cfg_we    <= 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 25) begin
          kind = kind_e'($urandom_range(0, 3));
          if ($urandom_range(0, 99) < 80) begin
            // well-formed shapes near the origin so queries land on them
            ax = window_coord();
            ay = window_coord();
            bx = window_coord();
            by = window_coord();
            if (kind == KIND_SEGMENT) begin
              if ($urandom_range(0, 1)) by = ay;
              else bx = ax;
            end
            radius = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 32767))
                                                 : 15'($urandom_range(1, 512));
          end else begin
            // raw bits, with forced coincidences to reach the reject paths
            ax     = 16'($urandom);
            ay     = 16'($urandom);
            bx     = 16'($urandom);
            by     = 16'($urandom);
            radius = 15'($urandom);
            if ($urandom_range(0, 3) == 0) bx = ax;
            if ($urandom_range(0, 3) == 0) by = ay;
            if ($urandom_range(0, 7) == 0) radius = '0;
          end
          send_add(kind, ax, ay, bx, by, radius, 8'($urandom));
        end else if ($urandom_range(0, 99) < 85) begin
          send_query(11'($urandom_range(0, 140)), 11'($urandom_range(0, 140)));
        end else begin
          send_query(11'($urandom), 11'($urandom));
        end
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d adds: %0d stored, %0d bad geometry, %0d on a full table",
             adds_stored + adds_bad + adds_full, adds_stored, adds_bad, adds_full);
    $display("and %0d pixel queries (%0d covered) over %0d depth filter settings",
             queries_hit + queries_miss, queries_hit, NUM_PHASES + 1);
    if (fail_count == 0) begin
      $display("[shape_table_pixel_coverage] OK");
    end else begin
      $display("[shape_table_pixel_coverage] ERROR");
    end
    $finish;
  end

endmodule

FILE: shape_table_pixel_coverage.f
+incdir+src
src/stpc_pkg.sv
src/stpc_front.sv
src/stpc_queue.sv
src/stpc_back.sv
src/shape_table_pixel_coverage.sv
tb/stpc_coverage_checker.sv
tb/tb_shape_table_pixel_coverage.sv
